// File: src/fpsm_pkg.sv
// shared types, constants and character classes for the format pattern matcher
package fpsm_pkg;

  localparam int PATTERN_BYTES_DEF = 32;
  localparam int CFG_WORDS         = 4;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 64;
  localparam int POS_W             = 6;
  localparam int COUNT_W           = 16;
  localparam int WIN_BYTES         = 3;

  // status codes
  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FMTERR   = 2'd3;

  // class codes
  localparam logic [1:0] CLS_LITERAL = 2'd0;
  localparam logic [1:0] CLS_DIGIT   = 2'd1;
  localparam logic [1:0] CLS_ALNUM   = 2'd2;
  localparam logic [1:0] CLS_HEX     = 2'd3;

  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_S   = 8'h73;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_PCT = 8'h25;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [1:0]         cls;
    logic               seen;
    logic [COUNT_W-1:0] count;
  } match_state_t;

  function automatic logic in_class(input logic [1:0] cls, input logic [7:0] b);
    logic dig;
    logic low;
    logic up;
    logic hex;
    dig = (b >= 8'h30) && (b <= 8'h39);
    low = (b >= 8'h61) && (b <= 8'h7a);
    up  = (b >= 8'h41) && (b <= 8'h5a);
    hex = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    case (cls)
      CLS_DIGIT: in_class = dig;
      CLS_ALNUM: in_class = dig || low || up;
      CLS_HEX:   in_class = dig || hex;
      default:   in_class = 1'b0;
    endcase
  endfunction

endpackage

// File: src/fpsm_pattern_store.sv
// pattern register file and three-byte lookup window at the current position
module fpsm_pattern_store
  import fpsm_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [POS_W-1:0]        pos,
  output logic [WIN_BYTES*8-1:0]  window
);

  localparam int PAT_W = PATTERN_BYTES * 8;

  logic [PAT_W-1:0]               pattern;
  logic [PAT_W+WIN_BYTES*8-1:0]   padded;
  logic [PAT_W+WIN_BYTES*8-1:0]   shifted;

  // each write lands in the eight bytes of its word that exist
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        if (cfg_index == CFG_IDX_W'(i / 8)) begin
          pattern[i*8 +: 8] <= cfg_data[(i % 8)*8 +: 8];
        end
      end
    end
  end

  // bytes past the end read as zero
  assign padded  = {{(WIN_BYTES*8){1'b0}}, pattern};
  assign shifted = padded >> {pos, 3'b000};
  assign window  = shifted[WIN_BYTES*8-1:0];

endmodule

// File: src/fpsm_match_step.sv
// per-byte match decision and next matcher state
module fpsm_match_step
  import fpsm_pkg::*;
(
  input  match_state_t            cur,
  input  logic                    restart,
  input  logic [7:0]              byte_req,
  input  logic [WIN_BYTES*8-1:0]  window,
  output logic [1:0]              status,
  output logic [COUNT_W-1:0]      match_length,
  output match_state_t            nxt
);

  match_state_t s;
  logic [7:0]   w0;
  logic [7:0]   w1;
  logic [7:0]   w2;
  logic [COUNT_W-1:0] cnt_inc;
  logic         fall;
  logic [1:0]   new_cls;

  always_comb begin
    s = restart ? '0 : cur;
    w0 = window[7:0];
    w1 = window[15:8];
    w2 = window[23:16];
    cnt_inc = (s.count == '1) ? s.count : s.count + COUNT_W'(1);
    status = ST_PENDING;
    fall = 1'b0;
    new_cls = CLS_LITERAL;
    case (w1)
      CH_U:    new_cls = CLS_DIGIT;
      CH_S:    new_cls = CLS_ALNUM;
      CH_X:    new_cls = CLS_HEX;
      default: new_cls = CLS_LITERAL;
    endcase

    if (s.cls != CLS_LITERAL) begin
      if (in_class(s.cls, byte_req)) begin
        s.count = cnt_inc;
        s.seen  = 1'b1;
        status  = (w0 == 8'h00) ? ST_MATCH : ST_PENDING;
      end else if (!s.seen) begin
        status = ST_MISMATCH;
      end else begin
        s.cls  = CLS_LITERAL;
        s.seen = 1'b0;
        fall   = 1'b1;
      end
    end else begin
      fall = 1'b1;
    end

    if (fall) begin
      if (w0 == 8'h00) begin
        status = ST_MATCH;
      end else if (w0 == CH_PCT) begin
        if (new_cls != CLS_LITERAL) begin
          s.cls = new_cls;
          s.pos = s.pos + POS_W'(2);
          if (!in_class(new_cls, byte_req)) begin
            status = ST_MISMATCH;
          end else begin
            s.count = cnt_inc;
            s.seen  = 1'b1;
            status  = (w2 == 8'h00) ? ST_MATCH : ST_PENDING;
          end
        end else if (w1 != CH_PCT) begin
          status = ST_FMTERR;
        end else if (byte_req != CH_PCT) begin
          status = ST_MISMATCH;
        end else begin
          // escaped percent sign consumes two pattern bytes
          s.pos   = s.pos + POS_W'(2);
          s.count = cnt_inc;
          status  = (w2 == 8'h00) ? ST_MATCH : ST_PENDING;
        end
      end else if (w0 != byte_req) begin
        status = ST_MISMATCH;
      end else begin
        s.pos   = s.pos + POS_W'(1);
        s.count = cnt_inc;
        status  = (w1 == 8'h00) ? ST_MATCH : ST_PENDING;
      end
    end

    match_length = (status == ST_MATCH) ? s.count : '0;
    nxt = (status == ST_PENDING) ? s : '0;
  end

endmodule

// File: src/format_pattern_stream_matcher.sv
// top level of the streaming format pattern matcher
//
// usage: received bytes enter on the s_ stream, one byte per transfer, with
// s_tuser set on the byte that abandons the current attempt and starts anew.
// every byte gives exactly one result transfer on the m_ stream carrying a
// status (pending, match, mismatch, format error) and the match length, which
// is nonzero only for a match. a final status returns the matcher to the
// pattern start for the next byte.
// the pattern is loaded through cfg_we/cfg_index/cfg_data, one 64-bit word
// of eight pattern bytes per write; the user must load it only while the
// stream is idle, which the block itself does not enforce. the input register
// loads at the transfer; the result register loads from it when the held byte
// moves on, which a stall can delay. throughput: one byte per cycle while
// m_tready stays high, set by the single compare step between the two registers.
// stall: when m_tready is low the result register holds, the input register
// still takes one more byte, then s_tready drops until the result is taken.
// reset (rst, synchronous) clears the pattern, the match state and both
// register valids.
module format_pattern_stream_matcher
  import fpsm_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] byte_req
  input  logic                  s_tuser,   // [0] restart
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata    // [1:0] status, [17:2] match_length, zero pad
);

  // input register
  logic                  in_vld;
  logic [7:0]            in_byte;
  logic                  in_restart;

  // result register
  logic                  out_vld;
  logic [1:0]            out_status;
  logic [COUNT_W-1:0]    out_len;

  // matcher state
  match_state_t          st;
  match_state_t          st_next;

  logic [WIN_BYTES*8-1:0] window;
  logic [1:0]             res_status;
  logic [COUNT_W-1:0]     res_len;
  logic                   proc_fire;
  logic                   in_fire;

  // the held byte moves on when the result register is empty or being drained
  assign proc_fire = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || proc_fire;
  assign in_fire   = s_tvalid && s_tready;

  fpsm_pattern_store #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos       (in_restart ? '0 : st.pos),
    .window    (window)
  );

  fpsm_match_step u_step (
    .cur          (st),
    .restart      (in_restart),
    .byte_req     (in_byte),
    .window       (window),
    .status       (res_status),
    .match_length (res_len),
    .nxt          (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_fire) begin
      in_vld <= 1'b1;
    end else if (proc_fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      st      <= '0;
    end else begin
      if (proc_fire) begin
        out_vld <= 1'b1;
        st      <= st_next;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_status <= res_status;
      out_len    <= res_len;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {6'b0, out_len, out_status};

  // a final status always sends the matcher back to the pattern start
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    proc_fire && (res_status != ST_PENDING) |=> (st.pos == '0) && (st.count == '0))
    else $error("state not cleared after final status");

  // only a match carries a length
  a_len_only_match: assert property (@(posedge clk) disable iff (rst)
    out_vld && (out_len != '0) |-> (out_status == ST_MATCH))
    else $error("length reported without match");

  // a held byte is never overwritten before it is processed
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_vld && !proc_fire |=> in_vld && $stable(in_byte) && $stable(in_restart))
    else $error("input register overwritten");

  // while an attempt continues, the consumed count never drops
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    proc_fire && (res_status == ST_PENDING) && !in_restart |=> st.count >= $past(st.count))
    else $error("match count decreased");

endmodule
